// ----- hw/rtl/slcf_pkg.sv -----
// Shared types and constants for the sync/length/CRC-8 frame parser.
// No dependencies; used by slcf_crc8 and sync_length_crc8_frame_parser.
`default_nettype none

package slcf_pkg;

  // CRC-8, MSB first, polynomial x^8 + x^2 + x + 1
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CRC_INIT  = 8'h00;

  // Register reset values
  localparam logic [7:0]  FIRST_SYNC_RST  = 8'hAA;
  localparam logic [7:0]  SECOND_SYNC_RST = 8'h55;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd250;

  // Result kinds
  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // Frame-end status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC_BAD   = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_t;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_FIRST_SYNC  = 2'd0,
    REG_SECOND_SYNC = 2'd1,
    REG_MAX_PAYLOAD = 2'd2
  } reg_index_t;

endpackage

`default_nettype wire

// ----- hw/rtl/slcf_crc8.sv -----
// Byte-wide CRC-8 update (MSB first), one byte per evaluation.
// Depends on slcf_pkg for the polynomial.
`default_nettype none

module slcf_crc8 (
  input  wire logic [7:0] crc_in,
  input  wire logic [7:0] data,
  output logic      [7:0] crc_out
);

  // Fold the byte in, then shift through eight bit steps
  always_comb begin
    logic [7:0] acc;
    acc = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (acc[7]) begin
        acc = {acc[6:0], 1'b0} ^ slcf_pkg::CRC_POLY;
      end else begin
        acc = {acc[6:0], 1'b0};
      end
    end
    crc_out = acc;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sync_length_crc8_frame_parser.sv -----
// Top level of the sync/length/CRC-8 frame parser: input register, parse
// logic, result register and APB configuration registers.
// Depends on slcf_pkg and slcf_crc8.
`default_nettype none

// The parser takes one received byte per beat and sustains one byte per clock
// cycle while the result side does not stall. An accepted byte sits in the
// input register, where the phase logic and a byte-wide CRC-8 update evaluate
// it; any result it causes is loaded into the result register when that byte
// advances. While a result is stalled the input register still takes one more
// byte; in_stall rises only when that register is also full. Frames are two
// sync bytes, a command byte, a big-endian 16-bit length, the payload and one
// CRC-8 check byte over the payload. Each payload byte comes out as a kind 0
// beat with its index; the check byte, or a length above max_payload, produces
// a kind 1 beat with last set and the status.
// Registers: first_sync at 0x0, second_sync at 0x4, max_payload at 0x8; write
// them only while the parser is idle.
module sync_length_crc8_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // input byte channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic      [7:0]  command,
  output logic      [7:0]  payload_byte,
  output logic      [15:0] byte_index,
  output logic      [15:0] frame_length,
  output logic      [1:0]  status,
  output logic             last,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_CMD     = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  // Configuration registers
  logic [7:0]  first_sync;
  logic [7:0]  second_sync;
  logic [15:0] max_payload;

  // Input register
  logic        in_full;
  logic [7:0]  in_byte;

  // Parse state
  phase_t      phase, phase_next;
  logic [7:0]  frame_command, frame_command_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] received_count, received_count_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [7:0]  crc_step;
  logic [15:0] count_inc;
  logic [15:0] length_lo;

  // Result produced by the byte in the input register
  logic                emit;
  logic                res_kind;
  logic [7:0]          res_byte;
  logic [15:0]         res_index;
  slcf_pkg::status_t   res_status;

  // Result register
  logic                out_kind;
  logic [7:0]          out_command;
  logic [7:0]          out_byte;
  logic [15:0]         out_index;
  logic [15:0]         out_length;
  slcf_pkg::status_t   out_status;

  logic fire;
  logic cfg_write;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= slcf_pkg::FIRST_SYNC_RST;
      second_sync <= slcf_pkg::SECOND_SYNC_RST;
      max_payload <= slcf_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_write) begin
      case (slcf_pkg::reg_index_t'(paddr[3:2]))
        slcf_pkg::REG_FIRST_SYNC:  first_sync  <= pwdata[7:0];
        slcf_pkg::REG_SECOND_SYNC: second_sync <= pwdata[7:0];
        slcf_pkg::REG_MAX_PAYLOAD: max_payload <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (slcf_pkg::reg_index_t'(paddr[3:2]))
      slcf_pkg::REG_FIRST_SYNC:  prdata = {24'd0, first_sync};
      slcf_pkg::REG_SECOND_SYNC: prdata = {24'd0, second_sync};
      slcf_pkg::REG_MAX_PAYLOAD: prdata = {16'd0, max_payload};
      default:                   prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  // Advance the input byte whenever the result register is free or draining
  assign fire     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  // Hold the byte while stalled
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  // ---------------------------------------------------------------- parse
  slcf_crc8 u_crc (
    .crc_in  (running_crc),
    .data    (in_byte),
    .crc_out (crc_step)
  );

  assign count_inc = received_count + 16'd1;
  assign length_lo = {payload_length[15:8], in_byte};

  always_comb begin
    phase_next          = phase;
    frame_command_next  = frame_command;
    payload_length_next = payload_length;
    received_count_next = received_count;
    running_crc_next    = running_crc;
    emit                = 1'b0;
    res_kind            = slcf_pkg::KIND_PAYLOAD;
    res_byte            = 8'd0;
    res_index           = 16'd0;
    res_status          = slcf_pkg::ST_OK;
    case (phase)
      PH_SYNC2: begin
        phase_next = (in_byte == second_sync) ? PH_CMD : PH_HUNT;
      end
      PH_CMD: begin
        frame_command_next = in_byte;
        phase_next         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        payload_length_next = {in_byte, 8'd0};
        phase_next          = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_length_next = length_lo;
        received_count_next = 16'd0;
        running_crc_next    = slcf_pkg::CRC_INIT;
        if (length_lo == 16'd0) begin
          phase_next = PH_CHECK;
        end else if (length_lo > max_payload) begin
          // abort oversized frame
          emit       = 1'b1;
          res_kind   = slcf_pkg::KIND_FRAME_END;
          res_status = slcf_pkg::ST_TOO_LARGE;
          phase_next = PH_HUNT;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit                = 1'b1;
        res_byte            = in_byte;
        res_index           = received_count;
        running_crc_next    = crc_step;
        received_count_next = count_inc;
        if (count_inc >= payload_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        emit       = 1'b1;
        res_kind   = slcf_pkg::KIND_FRAME_END;
        res_status = (in_byte == running_crc) ? slcf_pkg::ST_OK : slcf_pkg::ST_CRC_BAD;
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = (in_byte == first_sync) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

  // Hold parse state and advance it once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      frame_command  <= 8'd0;
      payload_length <= 16'd0;
      received_count <= 16'd0;
      running_crc    <= slcf_pkg::CRC_INIT;
    end else if (fire) begin
      phase          <= phase_next;
      frame_command  <= frame_command_next;
      payload_length <= payload_length_next;
      received_count <= received_count_next;
      running_crc    <= running_crc_next;
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load a new result beat; hold it while stalled
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_kind    <= res_kind;
      out_command <= frame_command_next;
      out_byte    <= res_byte;
      out_index   <= res_index;
      out_length  <= payload_length_next;
      out_status  <= res_status;
    end
  end

  assign kind         = out_kind;
  assign command      = out_command;
  assign payload_byte = out_byte;
  assign byte_index   = out_index;
  assign frame_length = out_length;
  assign status       = out_status;
  assign last         = (out_kind == slcf_pkg::KIND_FRAME_END);

`ifndef NO_ASSERTIONS
  // A payload beat never indexes past the announced length
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == slcf_pkg::KIND_PAYLOAD) |-> (byte_index < frame_length))
    else $error("payload index beyond frame length");

  // Payload beats carry ok status
  a_payload_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == slcf_pkg::KIND_PAYLOAD) |-> (status == slcf_pkg::ST_OK))
    else $error("payload beat with non-ok status");

  // In the payload phase the count stays below the length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (received_count < payload_length))
    else $error("payload count reached length inside payload phase");

  // Back-pressure only when both registers are occupied and downstream stalls
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

// ----- tb/frame_tb_pkg.sv -----
// Testbench helpers for the frame parser: byte-wise CRC-8 step shared by the
// stimulus and the result checker. Depends on slcf_pkg.
package frame_tb_pkg;

  import slcf_pkg::*;

  // Fold one byte into an MSB-first CRC-8
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

// ----- tb/frame_parse_checker.sv -----
// Result checker for the frame parser: watches the byte, result and register
// ports, predicts every result beat and compares it field by field.
// Depends on slcf_pkg and frame_tb_pkg.
module frame_parse_checker
  import slcf_pkg::*;
  import frame_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        kind,
  input  logic [7:0]  command,
  input  logic [7:0]  payload_byte,
  input  logic [15:0] byte_index,
  input  logic [15:0] frame_length,
  input  logic [1:0]  status,
  input  logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          open_count,
  output int          error_count,
  output int          payload_count,
  output int          ok_count,
  output int          crc_bad_count,
  output int          too_large_count
);

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_CMD, TAKE_LEN_HI, TAKE_LEN_LO, TAKE_PAYLOAD, TAKE_CHECK
  } parse_phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  command;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    status_t     status;
    logic        last;
  } frame_beat_t;

  // Register copies
  logic [7:0]   first_sync;
  logic [7:0]   second_sync;
  logic [15:0]  max_payload;

  // Parser state copy
  parse_phase_t phase;
  logic [7:0]   frame_cmd;
  logic [15:0]  frame_len;
  logic [15:0]  bytes_in_frame;
  logic [7:0]   payload_crc;

  frame_beat_t  awaited_results[$];

  initial begin
    error_count = 0;
    payload_count = 0;
    ok_count = 0;
    crc_bad_count = 0;
    too_large_count = 0;
  end

  // Queue one predicted result beat for the current frame
  task automatic await_beat(input logic k, input logic [7:0] pb, input logic [15:0] idx,
                            input status_t st);
    frame_beat_t beat;
    beat.kind = k;
    beat.command = frame_cmd;
    beat.payload_byte = pb;
    beat.byte_index = idx;
    beat.frame_length = frame_len;
    beat.status = st;
    beat.last = k;
    awaited_results.push_back(beat);
  endtask

  // Advance the parser by one received byte
  task automatic parse_rx_byte(input logic [7:0] b);
    case (phase)
      HUNT_SECOND: phase = (b == second_sync) ? TAKE_CMD : HUNT_FIRST;
      TAKE_CMD: begin
        frame_cmd = b;
        phase = TAKE_LEN_HI;
      end
      TAKE_LEN_HI: begin
        frame_len = {b, 8'h00};
        phase = TAKE_LEN_LO;
      end
      TAKE_LEN_LO: begin
        frame_len[7:0] = b;
        bytes_in_frame = '0;
        payload_crc = CRC_INIT;
        if (frame_len == 16'd0) begin
          phase = TAKE_CHECK;
        end else if (frame_len > max_payload) begin
          await_beat(KIND_FRAME_END, 8'h00, 16'd0, ST_TOO_LARGE);
          phase = HUNT_FIRST;
        end else begin
          phase = TAKE_PAYLOAD;
        end
      end
      TAKE_PAYLOAD: begin
        await_beat(KIND_PAYLOAD, b, bytes_in_frame, ST_OK);
        payload_crc = crc8_next(payload_crc, b);
        bytes_in_frame = bytes_in_frame + 16'd1;
        if (bytes_in_frame >= frame_len) phase = TAKE_CHECK;
      end
      TAKE_CHECK: begin
        await_beat(KIND_FRAME_END, 8'h00, 16'd0, (b == payload_crc) ? ST_OK : ST_CRC_BAD);
        phase = HUNT_FIRST;
      end
      default: phase = (b == first_sync) ? HUNT_SECOND : HUNT_FIRST;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Compare an accepted result beat with the oldest prediction
  task automatic check_result_beat();
    frame_beat_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: result beat with none expected: expected nothing, got kind %0d status %0d",
               $time, kind, status);
      error_count++;
    end else begin
      want = awaited_results.pop_front();
      check_field("kind", want.kind, kind);
      check_field("command", want.command, command);
      check_field("payload_byte", want.payload_byte, payload_byte);
      check_field("byte_index", want.byte_index, byte_index);
      check_field("frame_length", want.frame_length, frame_length);
      check_field("status", want.status, status);
      check_field("last", want.last, last);
    end
    if (kind == KIND_PAYLOAD) payload_count++;
    else if (status == ST_OK) ok_count++;
    else if (status == ST_CRC_BAD) crc_bad_count++;
    else too_large_count++;
  endtask

  // Sample all channels on the clock edge
  always @(posedge clk) begin
    if (rst) begin
      first_sync = FIRST_SYNC_RST;
      second_sync = SECOND_SYNC_RST;
      max_payload = MAX_PAYLOAD_RST;
      phase = HUNT_FIRST;
      frame_cmd = '0;
      frame_len = '0;
      bytes_in_frame = '0;
      payload_crc = CRC_INIT;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result_beat();
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FIRST_SYNC:  first_sync = pwdata[7:0];
          REG_SECOND_SYNC: second_sync = pwdata[7:0];
          REG_MAX_PAYLOAD: max_payload = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_rx_byte(rx_byte);
    end
    open_count <= awaited_results.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the frame parser testbench: clock, reset, byte and register stimulus,
// result-side stalls and the verdict. Depends on slcf_pkg, frame_tb_pkg,
// frame_parse_checker and the parser RTL.
module tb_top;

  import slcf_pkg::*;
  import frame_tb_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES    = 200000;
  localparam int unsigned BEATS_PER_SETTING = 280;
  localparam int unsigned SETTLE_CYCLES     = 4;
  localparam int unsigned HOLD_AT_BEAT      = 400;
  localparam int unsigned HOLD_CYCLES       = 250;
  localparam logic [1:0]  REG_UNUSED        = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  command;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [15:0] frame_length;
  logic [1:0]  status;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  int open_count, error_count, payload_count, ok_count, crc_bad_count, too_large_count;

  // Register values as last written, used to shape frames
  logic [7:0]  cfg_first = FIRST_SYNC_RST;
  logic [7:0]  cfg_second = SECOND_SYNC_RST;
  logic [15:0] cfg_max = MAX_PAYLOAD_RST;
  int unsigned bytes_sent = 0;

  sync_length_crc8_frame_parser u_top (
    .clk, .rst, .in_valid, .in_stall, .rx_byte,
    .out_valid, .out_stall, .kind, .command, .payload_byte, .byte_index,
    .frame_length, .status, .last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  frame_parse_checker u_parse_chk (
    .clk, .rst, .in_valid, .in_stall, .rx_byte,
    .out_valid, .out_stall, .kind, .command, .payload_byte, .byte_index,
    .frame_length, .status, .last,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .open_count, .error_count, .payload_count, .ok_count, .crc_bad_count, .too_large_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (((bytes_sent / 64) % 4) == 3) ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Send a complete frame; an oversize length gets no payload or check byte
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len, input bit check_ok);
    logic [7:0] crc;
    logic [7:0] b;
    send_byte(cfg_first);
    send_byte(cfg_second);
    send_byte(cmd);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (len <= cfg_max) begin
      crc = CRC_INIT;
      repeat (len) begin
        b = 8'($urandom);
        crc = crc8_next(crc, b);
        send_byte(b);
      end
      send_byte(check_ok ? crc : crc ^ (8'h01 << $urandom_range(0, 7)));
    end
  endtask

  // Mostly good frames, some bad checks, oversize lengths, broken syncs and noise
  task automatic send_random_unit();
    int unsigned pick;
    logic [15:0] len;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 70 || (pick < 80 && cfg_max == 16'hFFFF)) begin
      if ($urandom_range(0, 9) == 0 && cfg_max <= 16'd64) len = cfg_max;
      else len = 16'($urandom_range(0, (cfg_max < 16'd24) ? cfg_max : 24));
      send_frame(8'($urandom), len, $urandom_range(0, 4) != 0);
    end else if (pick < 80) begin
      if ($urandom_range(0, 7) == 0) len = 16'hFFFF;
      else len = 16'($urandom_range(cfg_max + 1, 16'hFFFF));
      send_frame(8'($urandom), len, 1'b1);
    end else if (pick < 90) begin
      send_byte(cfg_first);
      do b = 8'($urandom); while (b == cfg_second);
      send_byte(b);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        do b = 8'($urandom); while (b == cfg_first);
        send_byte(b);
      end
    end
  endtask

  // Drop valid and wait until every predicted beat has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Write all three registers; upper data bits are random and must be dropped
  task automatic set_config(input logic [7:0] f, input logic [7:0] s, input logic [15:0] m);
    apb_write(REG_FIRST_SYNC, {8'($urandom), f});
    apb_write(REG_SECOND_SYNC, {8'($urandom), s});
    apb_write(REG_MAX_PAYLOAD, m);
    cfg_first = f;
    cfg_second = s;
    cfg_max = m;
  endtask

  // Result side: random stalls, quiet stretches, one long hold-off
  initial begin
    int unsigned taken;
    int unsigned pause;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT_BEAT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pause = (((taken / 50) % 4) == 3) ? 0 : $urandom_range(0, 3);
      if (pause != 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned phase_start;
    logic [7:0]  sync_pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Zero length, bad check byte, wrong second sync, maximum oversize length
    send_frame(8'h00, 16'h0000, 1'b1);
    send_frame(8'hFF, 16'd2, 1'b0);
    send_byte(cfg_first);
    send_byte(cfg_first);
    send_byte(cfg_second);
    send_frame(8'h7E, 16'hFFFF, 1'b1);
    wait_idle();

    for (int setting = 0; setting < 5; setting++) begin
      case (setting)
        0: apb_write(REG_UNUSED, 16'($urandom));
        1: set_config(8'h00, 8'hFF, 16'h0000);
        2: set_config(8'hFF, 8'h00, 16'hFFFF);
        3: begin
          sync_pick = 8'($urandom);
          set_config(sync_pick, sync_pick, 16'd16);
        end
        default: set_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 60)));
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BEATS_PER_SETTING) send_random_unit();
      wait_idle();
    end

    $display("Sent %0d bytes under reset values and four register settings.", bytes_sent);
    $display("Checked %0d payload beats, %0d good frames, %0d crc errors, %0d oversize aborts.",
             payload_count, ok_count, crc_bad_count, too_large_count);
    if (error_count == 0 && open_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop in case the parser hangs
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Verification failed");
    $finish;
  end

endmodule
